### hdl/sliding_window_near_match_top_assert.svh
// Assertion macros shared by the near-match detector.
// Each macro checks one property on the rising edge of clk, outside reset.
`ifndef SLIDING_WINDOW_NEAR_MATCH_TOP_ASSERT_SVH
`define SLIDING_WINDOW_NEAR_MATCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define SWNM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("near-match detector: same-cycle check failed");

// Next-cycle implication.
`define SWNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("near-match detector: next-cycle check failed");

`endif

### hdl/swnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swnm_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 32;
  localparam int WIN_W      = 7;
  localparam int TOL_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd1;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_LEN_RST = 7'd1;
  localparam logic [TOL_W-1:0] TOLERANCE_RST  = 31'd0;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } swnm_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;
    logic issue_read;
    logic compare;
    logic finish;
  } swnm_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic span_zero;
    logic cmp_done;
    logic out_free;
  } swnm_sts_t;

endpackage

`default_nettype wire

### hdl/swnm_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample channel: one signed value and its first-item marker per item.
interface swnm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               first_item;

  modport source (output valid, output sample_value, output first_item, input ready);
  modport sink   (input valid, input sample_value, input first_item, output ready);
endinterface

// Result channel: the match flags for one sample.
interface swnm_out_if;
  logic valid;
  logic ready;
  logic near_match;
  logic any_match;

  modport source (output valid, output near_match, output any_match, input ready);
  modport sink   (input valid, input near_match, input any_match, output ready);
endinterface

`default_nettype wire

### hdl/sliding_window_near_match_top.sv
// Near-match detector over a sliding window of signed 32-bit samples. Each
// sample is compared, newest first, with up to min(window_len, MAX_WINDOW)
// earlier samples of its sequence, and one result item reports near_match and
// the sticky any_match; a sample with first_item set starts a new sequence.
// Samples are handled one at a time: a result is presented after the scan of
// its window and the write-back, and the next sample is accepted once the
// sequencer is back in idle. The scan covers the entries up to and including
// the first hit (at most the clipped window length, none for an empty window).
// The scan is paced by the window memory's single registered read port and
// the single 33-bit comparator, which take each entry through a read state
// and then a compare state. A waiting result does not block the next sample
// from being accepted; it only holds the final write-back until the output is free.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_near_match_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [swnm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swnm_pkg::CFG_DATA_W-1:0] cfg_data,
  swnm_in_if.sink                         samples,
  swnm_out_if.source                      results
);
  import swnm_pkg::*;

  swnm_cmd_t cmd;
  swnm_sts_t sts;

  // Sequencer.
  swnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Window store, comparator and result register.
  swnm_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (samples.sample_value),
    .first_item   (samples.first_item),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .near_match   (results.near_match),
    .any_match    (results.any_match)
  );

`include "sliding_window_near_match_top_assert.svh"

  // A reported near match is always reflected in the sticky flag.
  `SWNM_ASSERT_SAME(a_any_covers_near, results.valid && results.near_match, results.any_match)
  // Once an item is accepted the block is busy in the next cycle.
  `SWNM_ASSERT_NEXT(a_busy_after_accept, samples.valid && samples.ready, !samples.ready)
  // A compare that ends the scan is followed by write-back, not another read.
  `SWNM_ASSERT_NEXT(a_scan_stops, cmd.compare && sts.cmp_done, !cmd.issue_read && !cmd.compare)
  // An empty window goes straight to write-back without touching the memory.
  `SWNM_ASSERT_NEXT(a_empty_skips_read, cmd.accept && sts.span_zero, !cmd.issue_read)

endmodule

`default_nettype wire

### hdl/swnm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module swnm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  swnm_pkg::swnm_sts_t sts,
  output swnm_pkg::swnm_cmd_t cmd
);
  import swnm_pkg::*;

  swnm_state_t state;
  swnm_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. Each window entry passes through a read state and
  // a compare state; the scan stops at the first hit or the oldest entry.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.span_zero ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        cmd.issue_read = 1'b1;
        state_next     = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = sts.cmp_done ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/swnm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module swnm_datapath #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swnm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swnm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [swnm_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                first_item,
  input  swnm_pkg::swnm_cmd_t                 cmd,
  output swnm_pkg::swnm_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                near_match,
  output logic                                any_match
);
  import swnm_pkg::*;

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WINDOW - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_WINDOW);
  localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_WINDOW);

  // Configuration registers.
  logic [WIN_W-1:0] window_len;
  logic [TOL_W-1:0] value_tolerance;

  // Window store and its bookkeeping.
  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_data;
  logic [PTR_W-1:0]    write_pos;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    filled_count;
  logic [CNT_W-1:0]    remaining;
  logic                seen_match;

  // Per-item working registers.
  logic signed [SAMPLE_W-1:0] cur;
  logic                       hit;

  logic [CMP_W-1:0] win_ext;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] span_a;
  logic [CMP_W-1:0] span;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]        mag;
  logic                     hit_now;
  logic                     seen_merged;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len      <= WINDOW_LEN_RST;
      value_tolerance <= TOLERANCE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW_LEN) begin
        window_len <= cfg_data[WIN_W-1:0];
      end
      if (cfg_index == CFG_TOLERANCE) begin
        value_tolerance <= cfg_data[TOL_W-1:0];
      end
    end
  end

  // Number of entries to scan: window length, clipped to the store depth and
  // to the entries held in this sequence. A first item sees an empty window.
  always_comb begin
    win_ext  = CMP_W'(window_len);
    fill_ext = first_item ? '0 : CMP_W'(filled_count);
    span_a   = (win_ext > MAX_EXT) ? MAX_EXT : win_ext;
    span     = (span_a > fill_ext) ? fill_ext : span_a;
  end

  // Absolute difference at 33 bits against the tolerance.
  always_comb begin
    diff        = {cur[SAMPLE_W-1], cur} - {rd_data[SAMPLE_W-1], rd_data};
    mag         = diff[SAMPLE_W] ? (SAMPLE_W+1)'(0) - diff : diff;
    hit_now     = mag <= {2'b00, value_tolerance};
    seen_merged = seen_match | hit;
  end

  assign sts.span_zero = (span == '0);
  assign sts.cmp_done  = hit_now || (remaining == CNT_W'(1));
  assign sts.out_free  = !out_valid || out_ready;

  // Window memory: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      rd_data <= mem[rd_ptr];
    end
    if (cmd.finish) begin
      mem[write_pos] <= cur;
    end
  end

  // Scan registers; the read pointer walks backwards from the newest entry.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur       <= sample_value;
      hit       <= 1'b0;
      remaining <= span[CNT_W-1:0];
      rd_ptr    <= (write_pos == '0) ? LAST_PTR : write_pos - PTR_W'(1);
    end else if (cmd.compare) begin
      hit       <= hit | hit_now;
      remaining <= remaining - CNT_W'(1);
      rd_ptr    <= (rd_ptr == '0) ? LAST_PTR : rd_ptr - PTR_W'(1);
    end
  end

  // Sequence state: write pointer, fill count and sticky flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos    <= '0;
      filled_count <= '0;
      seen_match   <= 1'b0;
    end else if (cmd.accept && first_item) begin
      filled_count <= '0;
      seen_match   <= 1'b0;
    end else if (cmd.finish) begin
      write_pos  <= (write_pos == LAST_PTR) ? '0 : write_pos + PTR_W'(1);
      seen_match <= seen_merged;
      if (filled_count != FULL_CNT) begin
        filled_count <= filled_count + CNT_W'(1);
      end
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      near_match <= hit;
      any_match  <= seen_merged;
    end
  end

endmodule

`default_nettype wire
